/* rtl/bds_pkg.sv */
// Package for the divergence scorer: payload structs, op codes, register indexes.
// No dependencies.
package bds_pkg;

    localparam logic [1:0] OP_EXEC     = 2'd0;
    localparam logic [1:0] OP_ADD      = 2'd1;
    localparam logic [1:0] OP_NOGAIN   = 2'd2;
    localparam logic [1:0] OP_RESERVED = 2'd3;

    localparam logic [2:0] REG_WARMUP    = 3'd0;
    localparam logic [2:0] REG_THRESHOLD = 3'd1;
    localparam logic [2:0] REG_DECAY_NUM = 3'd2;
    localparam logic [2:0] REG_DECAY_DEN = 3'd3;
    localparam logic [2:0] REG_REWARD    = 3'd4;

    typedef struct packed {
        logic [1:0]  operation;
        logic        has_reference;
        logic        diverged;
        logic        killed;
        logic [31:0] div_key;
        logic [31:0] edges_seen;
    } bds_in_t;

    typedef struct packed {
        logic        skip;
        logic [7:0]  active_threshold;
        logic        warmup_complete;
        logic [7:0]  score_after;
        logic [31:0] mutation_total;
        logic [47:0] edge_total;
        logic [31:0] same_path_total;
        logic [31:0] divergent_total;
        logic [31:0] kill_total;
        logic [31:0] pass_total;
        logic [31:0] yield_total;
    } bds_out_t;

    // Score action the back end performs.
    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_READ   = 2'd1,
        ACT_DECAY  = 2'd2,
        ACT_REWARD = 2'd3
    } bds_act_t;

    function automatic logic [31:0] inc32(input logic [31:0] v);
        inc32 = (v == '1) ? v : v + 32'd1;
    endfunction

endpackage

/* rtl/bds_front.sv */
// Front end: accepts events, updates flags and counters, and issues score work.
// Depends on bds_pkg.
module bds_front #(
    parameter int KEY_W     = 16,
    parameter int TRACE_CAP = 65536
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  bds_pkg::bds_in_t     s_data,
    input  logic [31:0]          warmup_execs,
    input  logic [7:0]           threshold_default,
    output logic                 q_valid,
    input  logic                 q_ready,
    output bds_pkg::bds_act_t    q_act,
    output logic [KEY_W-1:0]     q_key,
    output bds_pkg::bds_out_t    q_res
);
    import bds_pkg::*;

    logic        warm_reg;
    logic [7:0]  thr_reg;
    logic        lp_valid_reg;
    logic [KEY_W-1:0] lp_key_reg;
    logic [31:0] mut_reg, same_reg, div_reg, kill_reg, pass_reg, yield_reg;
    logic [47:0] edge_reg;
    logic        qv_reg;
    bds_act_t    act_reg;
    logic [KEY_W-1:0] key_reg;
    bds_out_t    res_reg;

    logic        warm_next;
    logic [7:0]  thr_next;
    logic        lp_valid_next;
    logic [KEY_W-1:0] lp_key_next;
    logic [31:0] mut_next, same_next, div_next, kill_next, pass_next, yield_next;
    logic [47:0] edge_next;
    bds_act_t    act_next;
    logic [KEY_W-1:0] key_next;
    logic        skip_next;
    logic [31:0] edges_c;
    logic [48:0] edge_sum;
    logic [KEY_W-1:0] kin;

    assign s_ready = !qv_reg || q_ready;
    assign kin     = s_data.div_key[KEY_W-1:0];
    assign edges_c = (s_data.edges_seen > 32'(TRACE_CAP)) ? 32'(TRACE_CAP)
                                                         : s_data.edges_seen;
    assign edge_sum = {1'b0, edge_reg} + {17'd0, edges_c};

    // Event classification
    always_comb begin
        warm_next = warm_reg; thr_next = thr_reg;
        lp_valid_next = lp_valid_reg; lp_key_next = lp_key_reg;
        mut_next = mut_reg; edge_next = edge_reg; same_next = same_reg;
        div_next = div_reg; kill_next = kill_reg; pass_next = pass_reg;
        yield_next = yield_reg;
        act_next = ACT_NONE; key_next = kin; skip_next = 1'b0;
        case (s_data.operation)
            OP_EXEC: begin
                mut_next  = inc32(mut_reg);
                edge_next = edge_sum[48] ? '1 : edge_sum[47:0];
                if (!warm_reg && mut_next >= warmup_execs) begin
                    warm_next = 1'b1;
                    thr_next  = threshold_default;
                end
                if (!s_data.has_reference) begin
                    lp_valid_next = 1'b0;
                end else if (!s_data.diverged) begin
                    same_next = inc32(same_reg);
                    lp_valid_next = 1'b0;
                    skip_next = 1'b1;
                end else begin
                    div_next = inc32(div_reg);
                    if (s_data.killed) begin
                        kill_next = inc32(kill_reg);
                        lp_valid_next = 1'b0;
                        act_next = ACT_DECAY;
                        skip_next = 1'b1;
                    end else begin
                        pass_next = inc32(pass_reg);
                        lp_key_next = kin;
                        lp_valid_next = 1'b1;
                        act_next = ACT_READ; // score reported, not changed
                    end
                end
            end
            OP_ADD: begin
                if (lp_valid_reg) begin
                    yield_next = inc32(yield_reg);
                    act_next = ACT_REWARD;
                    key_next = lp_key_reg;
                end
            end
            OP_NOGAIN: begin
                if (lp_valid_reg) begin
                    act_next = ACT_DECAY;
                    key_next = lp_key_reg;
                end
            end
            default: ;
        endcase
    end

    // State and queue entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            warm_reg <= 1'b0; thr_reg <= '0; lp_valid_reg <= 1'b0; lp_key_reg <= '0;
            mut_reg <= '0; edge_reg <= '0; same_reg <= '0; div_reg <= '0;
            kill_reg <= '0; pass_reg <= '0; yield_reg <= '0; qv_reg <= 1'b0;
            act_reg <= ACT_NONE;
        end else begin
            qv_reg <= (s_valid && s_ready) || (qv_reg && !q_ready);
            if (s_valid && s_ready) begin
                warm_reg <= warm_next; thr_reg <= thr_next;
                lp_valid_reg <= lp_valid_next; lp_key_reg <= lp_key_next;
                mut_reg <= mut_next; edge_reg <= edge_next; same_reg <= same_next;
                div_reg <= div_next; kill_reg <= kill_next; pass_reg <= pass_next;
                yield_reg <= yield_next;
                act_reg <= act_next;
                key_reg <= key_next;
                // score_after is filled in by the back end
                res_reg.skip             <= skip_next;
                res_reg.active_threshold <= warm_next ? thr_next : 8'd0;
                res_reg.warmup_complete  <= warm_next;
                res_reg.score_after      <= '0;
                res_reg.mutation_total   <= mut_next;
                res_reg.edge_total       <= edge_next;
                res_reg.same_path_total  <= same_next;
                res_reg.divergent_total  <= div_next;
                res_reg.kill_total       <= kill_next;
                res_reg.pass_total       <= pass_next;
                res_reg.yield_total      <= yield_next;
            end
        end
    end

    assign q_valid = qv_reg;
    assign q_act   = act_reg;
    assign q_key   = key_reg;
    assign q_res   = res_reg;
endmodule

/* rtl/bds_back.sv */
// Back end: score table read-modify-write with a serial divider for decay.
// Depends on bds_pkg.
module bds_back #(
    parameter int KEY_W         = 16,
    parameter int INITIAL_SCORE = 128
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    output logic               q_ready,
    input  bds_pkg::bds_act_t  q_act,
    input  logic [KEY_W-1:0]   q_key,
    input  bds_pkg::bds_out_t  q_res,
    input  logic [7:0]         decay_num,
    input  logic [7:0]         decay_den,
    input  logic [7:0]         reward_step,
    output logic               m_valid,
    input  logic               m_ready,
    output bds_pkg::bds_out_t  m_data
);
    import bds_pkg::*;

    localparam int DEPTH = 1 << KEY_W;

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_READ, ST_CALC, ST_DIV, ST_WRITE, ST_OUT
    } state_t;

    logic [7:0]        mem [DEPTH];
    state_t            state_reg;
    logic [KEY_W:0]    clr_reg;
    logic [KEY_W-1:0]  key_reg;
    bds_act_t          act_reg;
    bds_out_t          res_reg;
    logic [7:0]        rd_reg;
    logic [15:0]       prod_reg;
    logic [15:0]       quo_reg;
    logic [8:0]        rem_reg;
    logic [4:0]        cnt_reg;
    logic [7:0]        score_reg;
    logic              mv_reg;
    logic [8:0]        rem_sh;
    logic [8:0]        rsum;
    logic              quo_bit;
    logic [15:0]       quo_sh;

    assign q_ready = (state_reg == ST_IDLE) && !mv_reg;
    assign rem_sh  = {rem_reg[7:0], prod_reg[15]};
    assign rsum    = {1'b0, rd_reg} + {1'b0, reward_step};
    assign quo_bit = (rem_sh >= {1'b0, decay_den});
    assign quo_sh  = {quo_reg[14:0], quo_bit};

    // Memory port
    always_ff @(posedge aclk) begin
        if (state_reg == ST_CLEAR) mem[clr_reg[KEY_W-1:0]] <= 8'(INITIAL_SCORE);
        else if (state_reg == ST_WRITE) mem[key_reg] <= score_reg;
        rd_reg <= mem[key_reg];
    end

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR; clr_reg <= '0; mv_reg <= 1'b0;
        end else begin
            mv_reg <= (state_reg == ST_OUT) || (mv_reg && !m_ready);
            case (state_reg)
                ST_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == (KEY_W+1)'(DEPTH - 1)) state_reg <= ST_IDLE;
                end
                ST_IDLE: if (q_valid && !mv_reg) begin
                    key_reg <= q_key; act_reg <= q_act;
                    res_reg <= q_res;
                    state_reg <= (q_act == ACT_NONE) ? ST_OUT : ST_READ;
                end
                ST_READ: state_reg <= ST_CALC;
                ST_CALC: begin
                    prod_reg <= {8'd0, rd_reg} * {8'd0, decay_num};
                    rem_reg <= '0; cnt_reg <= '0;
                    if (act_reg == ACT_READ) begin
                        score_reg <= rd_reg;
                        state_reg <= ST_WRITE;
                    end else if (act_reg == ACT_REWARD) begin
                        score_reg <= rsum[8] ? 8'hFF : rsum[7:0];
                        state_reg <= ST_WRITE;
                    end else if (decay_den == 8'd0) begin
                        score_reg <= 8'hFF;
                        state_reg <= ST_WRITE;
                    end else begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    // restoring division, one quotient bit per cycle
                    prod_reg <= {prod_reg[14:0], 1'b0};
                    rem_reg  <= quo_bit ? rem_sh - {1'b0, decay_den} : rem_sh;
                    quo_reg  <= quo_sh;
                    cnt_reg  <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd15) begin
                        score_reg <= (quo_sh[15:8] != 8'd0) ? 8'hFF : quo_sh[7:0];
                        state_reg <= ST_WRITE;
                    end
                end
                ST_WRITE: state_reg <= ST_OUT;
                ST_OUT: begin
                    res_reg.score_after <= (act_reg == ACT_NONE) ? 8'd0 : score_reg;
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid = mv_reg;
    assign m_data  = res_reg;
endmodule

/* rtl/bandit_divergence_scorer_core.sv */
// Top level of the divergence scorer: config registers, front end, back end.
// Depends on bds_pkg, bds_front, bds_back.
//
// Usage:
//   s_valid/s_ready/s_data carry one event item; m_valid/m_ready/m_data carry
//   the one result item each event gives. cfg_valid/cfg_ready/cfg_index/cfg_data
//   write a register (0 warmup_execs .. 4 reward_step); writes are always taken.
// Path: events that touch no score go from the queue register straight to the
//   result; a plain pass read, a reward or a zero-denominator decay pass the
//   table read-modify-write, and a decay also runs the 16-step serial divider
//   in the back end.
// Flow: one event is worked at a time in the back end; with m_ready high the
//   next starts in the cycle after a result is taken. The front end holds one
//   more in its queue register.
// Reset: synchronous active-low aresetn. After reset the back end sweeps the
//   score table to the initial score, one entry a cycle; the front end takes
//   one event into its queue meanwhile.
// Stall: a result waits in m_data while m_ready is low; the back end then
//   takes no new work and the front end fills and then drops s_ready.
module bandit_divergence_scorer_core #(
    parameter int TABLE_SIZE    = 65536,
    parameter int TRACE_CAP     = 65536,
    parameter int INITIAL_SCORE = 128
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  bds_pkg::bds_in_t   s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output bds_pkg::bds_out_t  m_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    import bds_pkg::*;

    localparam int KEY_W = $clog2(TABLE_SIZE);

    logic [31:0] warm_cfg_reg;
    logic [7:0]  thr_cfg_reg, num_cfg_reg, den_cfg_reg, rew_cfg_reg;
    logic        q_valid, q_ready;
    bds_act_t    q_act;
    logic [KEY_W-1:0] q_key;
    bds_out_t    q_res;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            warm_cfg_reg <= 32'd1024; thr_cfg_reg <= 8'd64;
            num_cfg_reg <= 8'd3; den_cfg_reg <= 8'd4; rew_cfg_reg <= 8'd32;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_WARMUP:    warm_cfg_reg <= cfg_data;
                REG_THRESHOLD: thr_cfg_reg  <= cfg_data[7:0];
                REG_DECAY_NUM: num_cfg_reg  <= cfg_data[7:0];
                REG_DECAY_DEN: den_cfg_reg  <= cfg_data[7:0];
                REG_REWARD:    rew_cfg_reg  <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    bds_front #(.KEY_W(KEY_W), .TRACE_CAP(TRACE_CAP)) u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data,
        .warmup_execs(warm_cfg_reg), .threshold_default(thr_cfg_reg),
        .q_valid, .q_ready, .q_act, .q_key, .q_res
    );

    bds_back #(.KEY_W(KEY_W), .INITIAL_SCORE(INITIAL_SCORE)) u_back (
        .aclk, .aresetn, .q_valid, .q_ready, .q_act, .q_key,
        .q_res, .decay_num(num_cfg_reg), .decay_den(den_cfg_reg),
        .reward_step(rew_cfg_reg), .m_valid, .m_ready, .m_data
    );
endmodule

/* rtl/bds_checker.sv */
// Port-level checker for the divergence scorer, bound to the top level.
// Depends on bds_pkg.
module bds_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input bds_pkg::bds_out_t m_data
);
    import bds_pkg::*;

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data)) else $error("result changed");

    // No threshold shows while warmup is running
    a_warm: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.warmup_complete |-> m_data.active_threshold == 8'd0)
        else $error("threshold during warmup");

    // Kills never exceed divergences
    a_kill: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.kill_total <= m_data.divergent_total)
        else $error("kill count too high");

    // No result right after reset release
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_valid) else $error("result out of reset");
endmodule

bind bandit_divergence_scorer_core bds_checker u_chk (
    .aclk, .aresetn, .m_valid, .m_ready, .m_data
);
